>>> rtl/voxel_ray_occupancy_marker_top_assert.svh
// Assertion macros used by the checker file vrom_checker.sv.
`ifndef VOXEL_RAY_OCCUPANCY_MARKER_TOP_ASSERT_SVH
`define VOXEL_RAY_OCCUPANCY_MARKER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VROM_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define VROM_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/vrom_pkg.sv
package vrom_pkg;

  localparam int GRID_X_DEF = 128;
  localparam int GRID_Y_DEF = 128;
  localparam int GRID_Z_DEF = 32;

  localparam int POS_W  = 10;
  localparam int CODE_W = 3;
  localparam int DM_W   = 10;
  localparam int ERR_W  = 13;
  localparam int CRD_W  = 11;
  localparam int CW2    = 12;
  localparam int T_W    = 21;

  localparam logic [CODE_W-1:0] CODE_EMPTY = 3'd0;
  localparam logic [CODE_W-1:0] CODE_DISC  = 3'd1;
  localparam logic [CODE_W-1:0] CODE_OBST  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_LINE  = 3'd3;
  localparam logic [CODE_W-1:0] CODE_OBJ   = 3'd5;

  typedef enum logic [1:0] {
    MODE_RAY   = 2'd0,
    MODE_MARK  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_SLIDE = 2'd3
  } mode_t;

  typedef struct packed {
    logic load;
    logic ray_init;
    logic ray_rd;
    logic ray_wr;
    logic end_wr;
    logic mark_wr;
    logic cell_rd;
    logic slide_init;
    logic slide_rd;
    logic slide_wr;
    logic clr_wr;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  ray_end;
    logic  slide_end;
    logic  clr_end;
    logic  out_free;
  } stat_t;

endpackage

>>> rtl/vrom_ram.sv
module vrom_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/vrom_ctrl.sv
module vrom_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  vrom_pkg::stat_t stat,
  output vrom_pkg::cmd_t  cmd
);
  import vrom_pkg::*;

  typedef enum logic [11:0] {
    ST_CLEAR  = 12'b0000_0000_0001,
    ST_IDLE   = 12'b0000_0000_0010,
    ST_OFF1   = 12'b0000_0000_0100,
    ST_OFF2   = 12'b0000_0000_1000,
    ST_RAY_RD = 12'b0000_0001_0000,
    ST_RAY_WR = 12'b0000_0010_0000,
    ST_END_WR = 12'b0000_0100_0000,
    ST_MARK   = 12'b0000_1000_0000,
    ST_CELL   = 12'b0001_0000_0000,
    ST_SL_RD  = 12'b0010_0000_0000,
    ST_SL_WR  = 12'b0100_0000_0000,
    ST_DONE   = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_OFF1;
        end
      end
      ST_OFF1: state_next = ST_OFF2;
      ST_OFF2: begin
        unique case (stat.mode)
          MODE_RAY: begin
            cmd.ray_init = 1'b1;
            state_next   = ST_RAY_RD;
          end
          MODE_MARK: state_next = ST_MARK;
          MODE_READ: state_next = ST_CELL;
          MODE_SLIDE: begin
            cmd.slide_init = 1'b1;
            state_next     = ST_SL_RD;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_RAY_RD: begin
        if (stat.ray_end) begin
          state_next = ST_END_WR;
        end else begin
          cmd.ray_rd = 1'b1;
          state_next = ST_RAY_WR;
        end
      end
      ST_RAY_WR: begin
        cmd.ray_wr = 1'b1;
        state_next = ST_RAY_RD;
      end
      ST_END_WR: begin
        cmd.end_wr = 1'b1;
        state_next = ST_DONE;
      end
      ST_MARK: begin
        cmd.mark_wr = 1'b1;
        state_next  = ST_DONE;
      end
      ST_CELL: begin
        cmd.cell_rd = 1'b1;
        state_next  = ST_DONE;
      end
      ST_SL_RD: begin
        cmd.slide_rd = 1'b1;
        state_next   = ST_SL_WR;
      end
      ST_SL_WR: begin
        cmd.slide_wr = 1'b1;
        state_next   = stat.slide_end ? ST_DONE : ST_SL_RD;
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

>>> rtl/vrom_dp.sv
module vrom_dp #(
  parameter int GRID_X = vrom_pkg::GRID_X_DEF,
  parameter int GRID_Y = vrom_pkg::GRID_Y_DEF,
  parameter int GRID_Z = vrom_pkg::GRID_Z_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [31:0]     s_tdata,
  input  logic [1:0]      s_tuser,
  input  vrom_pkg::cmd_t  cmd,
  output vrom_pkg::stat_t stat,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata
);
  import vrom_pkg::*;

  localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int AW    = $clog2(CELLS);
  localparam int OW    = AW + 10;
  localparam int GYZ_I = GRID_Y * GRID_Z;

  localparam logic signed [OW-1:0] GYZ = OW'(GYZ_I);
  localparam logic signed [OW-1:0] GZO = OW'(GRID_Z);
  localparam logic signed [OW-1:0] BX0 = OW'((GRID_X / 2) * GYZ_I);
  localparam logic signed [OW-1:0] BY0 = OW'((GRID_Y / 2) * GRID_Z);
  localparam logic signed [OW-1:0] BXT = OW'((GRID_X - 1) * GYZ_I);
  localparam logic signed [OW-1:0] BYT = OW'((GRID_Y - 1) * GRID_Z);

  localparam logic signed [CRD_W-1:0] CX0  = CRD_W'(GRID_X / 2);
  localparam logic signed [CRD_W-1:0] CY0  = CRD_W'(GRID_Y / 2);
  localparam logic signed [CRD_W-1:0] CZ0  = CRD_W'(GRID_Z / 2);
  localparam logic signed [CRD_W-1:0] XMAX = CRD_W'(GRID_X - 1);
  localparam logic signed [CRD_W-1:0] YMAX = CRD_W'(GRID_Y - 1);
  localparam logic signed [CRD_W-1:0] ZMAX = CRD_W'(GRID_Z - 1);
  localparam logic signed [CRD_W-1:0] ONE  = CRD_W'(1);

  localparam logic signed [CRD_W-1:0] GYM = CRD_W'(GRID_Y);
  localparam logic signed [CRD_W-1:0] GZM = CRD_W'(GRID_Z);
  localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

  function automatic logic rng(input logic signed [CW2-1:0] v,
                               input logic signed [CW2-1:0] hi);
    return (v >= 0) && (v <= hi);
  endfunction

  // latched item
  mode_t                    mode_q;
  logic signed [POS_W-1:0]  px, py, pz;
  logic                     det;

  logic signed [T_W-1:0]    tq;
  logic signed [OW-1:0]     off;

  // walk state; position, bases and directions are shared by ray and slide
  logic signed [CRD_W-1:0]  cx, cy, cz;
  logic signed [OW-1:0]     bx, by;
  logic                     up_x, up_y, up_z;
  logic signed [ERR_W-1:0]  ex, ey, ez;
  logic [DM_W-1:0]          dx, dy, dz, dm, cnt;
  logic [AW-1:0]            clr_cnt;

  logic [CODE_W-1:0]        oc;
  logic                     og;

  logic                     hit, cur_in, src_in;
  logic signed [OW-1:0]     cur_addr, src_addr;
  logic signed [CW2-1:0]    dxs, dys, dzs, adx, ady, adz;
  logic [DM_W-1:0]          dm_n;
  logic signed [ERR_W-1:0]  exa, eya, eza, dmE, dm2;
  logic                     stp_x, stp_y, stp_z;
  logic                     upx_n, upy_n, upz_n;
  logic                     x_end, y_end, z_end;

  logic                     we, re;
  logic [AW-1:0]            waddr, raddr;
  logic [CODE_W-1:0]        wdata, rdata;

  always_comb begin
    hit      = rng(CW2'(px), CW2'(XMAX)) && rng(CW2'(py), CW2'(YMAX)) &&
               rng(CW2'(pz), CW2'(ZMAX));
    cur_in   = rng(CW2'(cx), CW2'(XMAX)) && rng(CW2'(cy), CW2'(YMAX)) &&
               rng(CW2'(cz), CW2'(ZMAX));
    src_in   = rng(CW2'(cx) - CW2'(px), CW2'(XMAX)) &&
               rng(CW2'(cy) - CW2'(py), CW2'(YMAX)) &&
               rng(CW2'(cz) - CW2'(pz), CW2'(ZMAX));
    cur_addr = bx + by + OW'(cz);
    src_addr = cur_addr - off;

    dxs  = CW2'(px) - CW2'(CX0);
    dys  = CW2'(py) - CW2'(CY0);
    dzs  = CW2'(pz) - CW2'(CZ0);
    adx  = (dxs < 0) ? -dxs : dxs;
    ady  = (dys < 0) ? -dys : dys;
    adz  = (dzs < 0) ? -dzs : dzs;
    dm_n = adx[DM_W-1:0];
    if (ady[DM_W-1:0] > dm_n) dm_n = ady[DM_W-1:0];
    if (adz[DM_W-1:0] > dm_n) dm_n = adz[DM_W-1:0];

    dmE   = $signed({3'b000, dm});
    dm2   = $signed({2'b00, dm, 1'b0});
    exa   = ex + $signed({2'b00, dx, 1'b0});
    eya   = ey + $signed({2'b00, dy, 1'b0});
    eza   = ez + $signed({2'b00, dz, 1'b0});
    stp_x = (exa >= dmE);
    stp_y = (eya >= dmE);
    stp_z = (eza >= dmE);

    // slide walks each axis against its shift so sources are read before overwrite
    upx_n = !(px > 0);
    upy_n = !(py > 0);
    upz_n = !(pz > 0);
    x_end = up_x ? (cx == XMAX) : (cx == '0);
    y_end = up_y ? (cy == YMAX) : (cy == '0);
    z_end = up_z ? (cz == ZMAX) : (cz == '0);
  end

  always_ff @(posedge clk) begin
    tq  <= T_W'(px) * T_W'(GYM) + T_W'(py);
    off <= OW'(tq) * OW'(GZM) + OW'(pz);

    if (cmd.load) begin
      mode_q <= mode_t'(s_tuser);
      px     <= s_tdata[9:0];
      py     <= s_tdata[19:10];
      pz     <= s_tdata[29:20];
      det    <= s_tdata[30];
    end

    if (cmd.ray_init) begin
      cx   <= CX0;
      cy   <= CY0;
      cz   <= CZ0;
      bx   <= BX0;
      by   <= BY0;
      ex   <= '0;
      ey   <= '0;
      ez   <= '0;
      dx   <= adx[DM_W-1:0];
      dy   <= ady[DM_W-1:0];
      dz   <= adz[DM_W-1:0];
      up_x <= (dxs > 0);
      up_y <= (dys > 0);
      up_z <= (dzs > 0);
      dm   <= dm_n;
      cnt  <= '0;
    end

    if (cmd.ray_wr) begin
      cnt <= cnt + 1'b1;
      ex  <= stp_x ? exa - dm2 : exa;
      ey  <= stp_y ? eya - dm2 : eya;
      ez  <= stp_z ? eza - dm2 : eza;
      if (stp_x) begin
        cx <= up_x ? cx + ONE : cx - ONE;
        bx <= up_x ? bx + GYZ : bx - GYZ;
      end
      if (stp_y) begin
        cy <= up_y ? cy + ONE : cy - ONE;
        by <= up_y ? by + GZO : by - GZO;
      end
      if (stp_z) begin
        cz <= up_z ? cz + ONE : cz - ONE;
      end
    end

    if (cmd.slide_init) begin
      up_x <= upx_n;
      up_y <= upy_n;
      up_z <= upz_n;
      cx   <= upx_n ? '0 : XMAX;
      cy   <= upy_n ? '0 : YMAX;
      cz   <= upz_n ? '0 : ZMAX;
      bx   <= upx_n ? '0 : BXT;
      by   <= upy_n ? '0 : BYT;
    end

    if (cmd.slide_wr) begin
      if (!z_end) begin
        cz <= up_z ? cz + ONE : cz - ONE;
      end else begin
        cz <= up_z ? '0 : ZMAX;
        if (!y_end) begin
          cy <= up_y ? cy + ONE : cy - ONE;
          by <= up_y ? by + GZO : by - GZO;
        end else begin
          cy <= up_y ? '0 : YMAX;
          by <= up_y ? '0 : BYT;
          cx <= up_x ? cx + ONE : cx - ONE;
          bx <= up_x ? bx + GYZ : bx - GYZ;
        end
      end
    end

    if (cmd.res_load) begin
      oc <= (mode_q == MODE_READ && hit) ? rdata : CODE_EMPTY;
      og <= (mode_q != MODE_SLIDE) && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    re    = cmd.ray_rd | cmd.slide_rd | cmd.cell_rd;
    raddr = off[AW-1:0];
    if (cmd.ray_rd)   raddr = cur_addr[AW-1:0];
    if (cmd.slide_rd) raddr = src_addr[AW-1:0];

    we    = 1'b0;
    waddr = cur_addr[AW-1:0];
    wdata = CODE_EMPTY;
    if (cmd.clr_wr) begin
      we    = 1'b1;
      waddr = clr_cnt;
    end
    if (cmd.ray_wr) begin
      we    = cur_in && (rdata == CODE_EMPTY);
      wdata = CODE_DISC;
    end
    if (cmd.end_wr) begin
      we    = hit;
      waddr = off[AW-1:0];
      wdata = CODE_OBST;
    end
    if (cmd.mark_wr) begin
      we    = hit;
      waddr = off[AW-1:0];
      wdata = det ? CODE_LINE : CODE_OBJ;
    end
    if (cmd.slide_wr) begin
      we    = 1'b1;
      wdata = src_in ? rdata : CODE_EMPTY;
    end
  end

  vrom_ram #(
    .WIDTH(CODE_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign stat.mode      = mode_q;
  assign stat.ray_end   = (cnt == dm);
  assign stat.slide_end = x_end && y_end && z_end;
  assign stat.clr_end   = (clr_cnt == LAST);
  assign stat.out_free  = !m_tvalid || m_tready;

  assign m_tdata = {4'b0000, og, oc};

endmodule

>>> rtl/voxel_ray_occupancy_marker_top.sv
// Occupancy grid of GRID_X*GRID_Y*GRID_Z 3-bit cell codes in one block RAM with one
// write and one registered read port. After reset the block sweeps the RAM to zero,
// one cell a cycle, and takes no beat until done. Items then run one at a time. Each
// cell visited costs a read-modify-write on the RAM, a read state then a write state.
// A sonar ray visits dm cells, dm being the largest axis distance from grid center to
// endpoint, and then marks the endpoint as an obstacle; a mark or a read touches one
// cell; a slide passes over every cell. The block goes back to idle before the next
// beat can be taken, and a result stalled at the output holds the following item in
// its done state until the output register frees up.
// A new beat is taken while the previous result still waits at the output.
module voxel_ray_occupancy_marker_top #(
  parameter int GRID_X = vrom_pkg::GRID_X_DEF,
  parameter int GRID_Y = vrom_pkg::GRID_Y_DEF,
  parameter int GRID_Z = vrom_pkg::GRID_Z_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // pos_x[9:0], pos_y[19:10], pos_z[29:20], det_type[30], 0
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // cell_code[2:0], in_grid[3], 0
);
  import vrom_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  vrom_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  vrom_dp #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .stat    (stat),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule

>>> rtl/vrom_checker.sv
`include "voxel_ray_occupancy_marker_top_assert.svh"

module vrom_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  `VROM_AST_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat dropped or changed while stalled")
  `VROM_AST_NOW(a_code_in_grid, m_tvalid && m_tdata[2:0] != 3'd0, m_tdata[3], "nonzero cell code outside grid")
  `VROM_AST_NOW(a_code_legal, m_tvalid, m_tdata[2:0] != 3'd4 && m_tdata[2:0] != 3'd6 && m_tdata[2:0] != 3'd7, "undefined cell code")
  `VROM_AST_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second beat taken before the first is done")
  `VROM_AST_NOW(a_clear_first, $fell(rst), !s_tready, "beat taken before clearing pass")

endmodule

bind voxel_ray_occupancy_marker_top vrom_checker u_vrom_checker (.*);

>>> dv/occupancy_checker.sv
`timescale 1ns / 1ps
module occupancy_checker #(
  parameter int GX = vrom_pkg::GRID_X_DEF,
  parameter int GY = vrom_pkg::GRID_Y_DEF,
  parameter int GZ = vrom_pkg::GRID_Z_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  output int          fail_count,
  output int          pending,
  output int          result_count
);
  import vrom_pkg::*;

  localparam int CELLS = GX * GY * GZ;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              in_grid;
  } cell_result_t;

  bit [CODE_W-1:0] occ [CELLS];
  bit [CODE_W-1:0] occ_shift [CELLS];
  cell_result_t    result_q [$];

  function automatic bit in_bounds(int x, int y, int z);
    return x >= 0 && x < GX && y >= 0 && y < GY && z >= 0 && z < GZ;
  endfunction

  function automatic int addr(int x, int y, int z);
    return (x * GY + y) * GZ + z;
  endfunction

  function automatic int mag(int v);
    return v < 0 ? -v : v;
  endfunction

  // Bresenham walk from the center; the endpoint is not visited here
  function automatic void walk_ray(int tx, int ty, int tz);
    int x, y, z, dx, dy, dz, sx, sy, sz, dm, ex, ey, ez;
    x = GX / 2; y = GY / 2; z = GZ / 2;
    dx = mag(tx - x); dy = mag(ty - y); dz = mag(tz - z);
    sx = x < tx ? 1 : -1;
    sy = y < ty ? 1 : -1;
    sz = z < tz ? 1 : -1;
    dm = dx;
    if (dy > dm) dm = dy;
    if (dz > dm) dm = dz;
    ex = 0; ey = 0; ez = 0;
    for (int i = 0; i < dm; i++) begin
      if (in_bounds(x, y, z) && occ[addr(x, y, z)] == CODE_EMPTY)
        occ[addr(x, y, z)] = CODE_DISC;
      ex += 2 * dx; ey += 2 * dy; ez += 2 * dz;
      if (ex >= dm) begin x += sx; ex -= 2 * dm; end
      if (ey >= dm) begin y += sy; ey -= 2 * dm; end
      if (ez >= dm) begin z += sz; ez -= 2 * dm; end
    end
  endfunction

  function automatic void shift_grid(int sx, int sy, int sz);
    for (int x = 0; x < GX; x++)
      for (int y = 0; y < GY; y++)
        for (int z = 0; z < GZ; z++)
          occ_shift[addr(x, y, z)] = in_bounds(x - sx, y - sy, z - sz) ?
                                     occ[addr(x - sx, y - sy, z - sz)] : CODE_EMPTY;
    occ = occ_shift;
  endfunction

  function automatic cell_result_t apply_beat(mode_t mode, int px, int py, int pz,
                                              logic det);
    cell_result_t r;
    bit hit;
    hit = in_bounds(px, py, pz);
    r.code = CODE_EMPTY;
    r.in_grid = hit;
    case (mode)
      MODE_RAY: begin
        walk_ray(px, py, pz);
        if (hit) occ[addr(px, py, pz)] = CODE_OBST;
      end
      MODE_MARK: begin
        if (hit) occ[addr(px, py, pz)] = det ? CODE_LINE : CODE_OBJ;
      end
      MODE_READ: begin
        if (hit) r.code = occ[addr(px, py, pz)];
      end
      default: begin
        shift_grid(px, py, pz);
        r.in_grid = 1'b0;
      end
    endcase
    return r;
  endfunction

  assign pending = result_q.size();

  initial begin
    fail_count = 0;
    result_count = 0;
  end

  always @(posedge clk) begin
    cell_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        result_count <= result_count + 1;
        if (result_q.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("%0t: unexpected result beat %h", $time, m_tdata);
        end else begin
          want = result_q.pop_front();
          if (m_tdata[2:0] !== want.code || m_tdata[3] !== want.in_grid ||
              m_tdata[7:4] !== 4'd0) begin
            fail_count <= fail_count + 1;
            $display("%0t: mismatch: expected code %0d in_grid %0b, got code %0d in_grid %0b (raw %h)",
                     $time, want.code, want.in_grid, m_tdata[2:0], m_tdata[3], m_tdata);
          end
        end
      end
      // queue the expected result behind any still waiting
      if (s_tvalid && s_tready)
        result_q = {result_q, apply_beat(mode_t'(s_tuser),
                                         int'($signed(s_tdata[9:0])),
                                         int'($signed(s_tdata[19:10])),
                                         int'($signed(s_tdata[29:20])), s_tdata[30])};
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import vrom_pkg::*;

  localparam int GX = GRID_X_DEF;
  localparam int GY = GRID_Y_DEF;
  localparam int GZ = GRID_Z_DEF;
  localparam int RANDOM_ITEMS = 1930;
  localparam int QUIET_TAIL = 200;
  localparam int STALL_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  int fail_count, pending, result_count;
  int mode_count [4];
  int stall_cycles = 0;
  bit quiet = 1'b0;
  bit held_off = 1'b0;
  bit tx_idle_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  voxel_ray_occupancy_marker_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  occupancy_checker #(.GX(GX), .GY(GY), .GZ(GZ)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  // Watchdog: the reset sweep and each slide take long stretches with no beats
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("voxel_ray_occupancy_marker_top regression: fail");
      $finish;
    end
  end

  // Receiver: random back-pressure, one long hold-off to fill the block
  initial begin
    forever begin
      @(negedge clk);
      if (!held_off && result_count >= 300) begin
        held_off = 1'b1;
        m_tready = 1'b0;
        repeat (400) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      m_tready = 1'b1;
    end
  end

  task automatic send_item(mode_t mode, int px, int py, int pz, bit det);
    if (!quiet && tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tuser = mode;
    s_tdata = {1'b0, det, pz[9:0], py[9:0], px[9:0]};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    mode_count[mode]++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Coordinates: mostly near the center, some anywhere in the grid, some anywhere at all
  function automatic int pick_coord(int extent);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return extent / 2 + $urandom_range(0, 24) - 12;
    if (sel < 9) return $urandom_range(0, extent - 1);
    return $urandom_range(0, 1023) - 512;
  endfunction

  initial begin
    int sel;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    send_item(MODE_READ, GX / 2, GY / 2, GZ / 2, 1'b0);
    send_item(MODE_RAY, GX / 2, GY / 2, GZ / 2, 1'b1);
    send_item(MODE_READ, GX / 2, GY / 2, GZ / 2, 1'b0);
    send_item(MODE_RAY, 0, 0, 0, 1'b0);
    send_item(MODE_READ, 32, 32, 8, 1'b0);
    send_item(MODE_READ, 0, 0, 0, 1'b1);
    send_item(MODE_RAY, GX - 1, GY - 1, GZ - 1, 1'b0);
    send_item(MODE_RAY, 511, -512, -512, 1'b1);
    send_item(MODE_RAY, -512, 511, 511, 1'b0);
    send_item(MODE_MARK, 70, 60, 10, 1'b0);
    send_item(MODE_MARK, 71, 60, 10, 1'b1);
    send_item(MODE_MARK, GX, 0, 0, 1'b0);
    send_item(MODE_MARK, 0, GY - 1, -1, 1'b1);
    send_item(MODE_READ, 70, 60, 10, 1'b1);
    send_item(MODE_READ, 71, 60, 10, 1'b0);
    send_item(MODE_READ, -1, 5, 5, 1'b0);
    send_item(MODE_READ, 5, 5, GZ, 1'b1);
    send_item(MODE_SLIDE, 3, -2, 1, 1'b1);
    send_item(MODE_READ, GX / 2 + 3, GY / 2 - 2, GZ / 2 + 1, 1'b0);
    send_item(MODE_READ, 73, 58, 11, 1'b0);
    send_item(MODE_READ, 0, GY - 1, 0, 1'b0);
    send_item(MODE_SLIDE, -200, 511, -512, 1'b0);
    send_item(MODE_READ, GX / 2 + 3, GY / 2 - 2, GZ / 2 + 1, 1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) tx_idle_on = ($urandom_range(0, 3) != 0);
      if (n >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      sel = $urandom_range(0, 19);
      if (sel < 6)
        send_item(MODE_RAY, pick_coord(GX), pick_coord(GY), pick_coord(GZ), $urandom_range(0, 1));
      else if (sel < 11)
        send_item(MODE_MARK, pick_coord(GX), pick_coord(GY), pick_coord(GZ), $urandom_range(0, 1));
      else
        send_item(MODE_READ, pick_coord(GX), pick_coord(GY), pick_coord(GZ), $urandom_range(0, 1));
    end

    quiet = 1'b1;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d rays, %0d marks, %0d reads, %0d slides; %0d results checked.",
             mode_count[MODE_RAY], mode_count[MODE_MARK], mode_count[MODE_READ],
             mode_count[MODE_SLIDE], result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("voxel_ray_occupancy_marker_top regression: pass");
    end else begin
      $display("voxel_ray_occupancy_marker_top regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/vrom_pkg.sv
rtl/vrom_ram.sv
rtl/vrom_ctrl.sv
rtl/vrom_dp.sv
rtl/voxel_ray_occupancy_marker_top.sv
rtl/vrom_checker.sv
dv/occupancy_checker.sv
dv/tb_top.sv
